/* rtl/tmcr_pkg.sv */
// ============================================================================
// tmcr_pkg
// Shared types, constants and helpers for the text-mode cell renderer.
// ============================================================================
package tmcr_pkg;

    // Default geometry
    localparam int COLUMNS_DEF      = 128;
    localparam int MAX_ROWS_DEF     = 64;
    localparam int GLYPH_HEIGHT_DEF = 16;

    // Font store: 256 glyphs, glyph row index always takes four address bits
    localparam int FONT_DEPTH = 4096;
    localparam int FONT_AW    = 12;

    // Stream payload widths
    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 128;
    localparam int M_TUSER_W = 1;

    // Configuration port
    localparam int APB_AW = 6;
    localparam int APB_DW = 64;

    // Register indexes (paddr[5:3])
    localparam logic [2:0] REG_PAL_LOW      = 3'd0;
    localparam logic [2:0] REG_PAL_MID_LOW  = 3'd1;
    localparam logic [2:0] REG_PAL_MID_HIGH = 3'd2;
    localparam logic [2:0] REG_PAL_HIGH     = 3'd3;
    localparam logic [2:0] REG_ROWS_SHOWN   = 3'd4;

    localparam logic [6:0] ROWS_SHOWN_RST = 7'd37;

    // Request kinds carried in s_tuser
    localparam logic [1:0] REQ_WR_CELL = 2'd0;
    localparam logic [1:0] REQ_WR_FONT = 2'd1;
    localparam logic [1:0] REQ_RENDER  = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADDR,
        ST_CELL,
        ST_OUT
    } t_state;

    // Configuration registers as seen by the datapath
    typedef struct packed {
        logic [3:0][63:0] pal;
        logic [6:0]       rows_shown;
    } t_cfg;

    // Pick one RGB565 colour out of the 16-entry palette
    function automatic logic [15:0] pal_pick(input logic [3:0][63:0] pal,
                                             input logic [3:0] idx);
        logic [63:0] word;
        word = pal[idx[3:2]];
        return word[{idx[1:0], 4'b0000} +: 16];
    endfunction

endpackage

/* rtl/text_mode_cell_renderer.sv */
// ============================================================================
// text_mode_cell_renderer
// Character generator: cell store plus font store, renders 8 RGB565 pixels.
// ============================================================================
// After reset the block sweeps both stores to zero, one address per cycle,
// up to the larger of the two store depths; s_tready stays low meanwhile
// while APB writes are taken as usual. Cell and font writes are then done
// in the idle state without leaving it. A render steps through accept
// (text row by reciprocal multiply), address (cell address, glyph row and
// cell store read), font store read and output load; the slice then sits in
// the output register, and the next transaction can be accepted while it
// waits. The two dependent memory reads set the length of this sequence.
// ============================================================================
module text_mode_cell_renderer #(
    parameter int COLUMNS      = tmcr_pkg::COLUMNS_DEF,
    parameter int MAX_ROWS     = tmcr_pkg::MAX_ROWS_DEF,
    parameter int GLYPH_HEIGHT = tmcr_pkg::GLYPH_HEIGHT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // slave stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // cell_row[5:0], column[12:6], screen_line[22:13], char_code[30:23],
    // attribute[38:31], glyph_line[42:39], glyph_bits[50:43], zero fill
    input  logic [tmcr_pkg::S_TDATA_W-1:0]  s_tdata,
    // req_type[1:0]
    input  logic [tmcr_pkg::S_TUSER_W-1:0]  s_tuser,
    // master stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // pixel_0[15:0] .. pixel_7[127:112]
    output logic [tmcr_pkg::M_TDATA_W-1:0]  m_tdata,
    // row_blank[0]
    output logic [tmcr_pkg::M_TUSER_W-1:0]  m_tuser,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tmcr_pkg::APB_AW-1:0]     paddr,
    input  logic [tmcr_pkg::APB_DW-1:0]     pwdata,
    output logic [tmcr_pkg::APB_DW-1:0]     prdata,
    output logic                            pready
);

    localparam int CELL_DEPTH = MAX_ROWS * COLUMNS;
    localparam int CELL_AW    = (CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1;
    localparam int FONT_AW    = tmcr_pkg::FONT_AW;
    localparam int CLR_DEPTH  = (CELL_DEPTH > tmcr_pkg::FONT_DEPTH) ?
                                CELL_DEPTH : tmcr_pkg::FONT_DEPTH;
    localparam int CLR_AW     = $clog2(CLR_DEPTH);
    localparam int M_TDATA_W_L = tmcr_pkg::M_TDATA_W;
    // line / GLYPH_HEIGHT as (line * DIV_M) >> DIV_SH, exact for 10-bit lines
    localparam int DIV_SH     = 20;
    localparam int DIV_M      = ((1 << DIV_SH) + GLYPH_HEIGHT - 1) / GLYPH_HEIGHT;

    localparam logic [CLR_AW:0]   CELL_DEPTH_C = (CLR_AW+1)'(CELL_DEPTH);
    localparam logic [CLR_AW:0]   FONT_DEPTH_C = (CLR_AW+1)'(tmcr_pkg::FONT_DEPTH);
    localparam logic [CLR_AW-1:0] CLR_LAST     = CLR_AW'(CLR_DEPTH - 1);

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    tmcr_pkg::t_cfg w_cfg;

    tmcr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // ------------------------------------------------------------------
    // Input fields
    // ------------------------------------------------------------------
    logic [1:0] w_req;
    logic [5:0] w_cell_row;
    logic [6:0] w_column;
    logic [9:0] w_line;
    logic [7:0] w_char;
    logic [7:0] w_attr;
    logic [3:0] w_gline;
    logic [7:0] w_gbits;

    assign w_req      = s_tuser[1:0];
    assign w_cell_row = s_tdata[5:0];
    assign w_column   = s_tdata[12:6];
    assign w_line     = s_tdata[22:13];
    assign w_char     = s_tdata[30:23];
    assign w_attr     = s_tdata[38:31];
    assign w_gline    = s_tdata[42:39];
    assign w_gbits    = s_tdata[50:43];

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    tmcr_pkg::t_state r_state, n_state;
    logic [CLR_AW-1:0] r_clr, n_clr;
    logic              r_m_valid, n_m_valid;
    logic              w_acc;
    logic              w_out_load;

    // Render payload
    logic [9:0]  r_line;
    logic [6:0]  r_col;
    logic [9:0]  r_q;
    logic        r_blank;
    logic [3:0]  r_gy;
    logic [M_TDATA_W_L-1:0] r_m_data;
    logic        r_m_blank;

    // ------------------------------------------------------------------
    // Accept-stage arithmetic
    // ------------------------------------------------------------------
    logic [30:0] w_div_prod;
    logic [9:0]  w_q;
    logic        w_blank;
    logic [13:0] w_wr_sum;
    logic        w_wr_cell_ok;
    logic        w_wr_font_ok;

    assign w_div_prod   = 31'(w_line) * 31'(DIV_M);
    assign w_q          = w_div_prod[DIV_SH+9:DIV_SH];
    assign w_blank      = (w_q >= 10'(w_cfg.rows_shown)) || (w_q >= 10'(MAX_ROWS))
                          || (8'(w_column) >= 8'(COLUMNS));
    assign w_wr_sum     = 14'(w_cell_row) * 14'(COLUMNS) + 14'(w_column);
    assign w_wr_cell_ok = (7'(w_cell_row) < 7'(MAX_ROWS)) && (8'(w_column) < 8'(COLUMNS));
    assign w_wr_font_ok = (5'(w_gline) < 5'(GLYPH_HEIGHT));

    // Address stage: glyph row and cell read address
    logic [13:0] w_rd_sum;
    logic [3:0]  w_gy;

    assign w_rd_sum = 14'(r_q) * 14'(COLUMNS) + 14'(r_col);
    assign w_gy     = 4'(r_line) - 4'(r_q * 10'(GLYPH_HEIGHT));

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        s_tready   = 1'b0;
        w_out_load = 1'b0;
        case (r_state)
            tmcr_pkg::ST_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == CLR_LAST) begin
                    n_state = tmcr_pkg::ST_IDLE;
                end
            end
            tmcr_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid && w_req == tmcr_pkg::REQ_RENDER) begin
                    n_state = tmcr_pkg::ST_ADDR;
                end
            end
            tmcr_pkg::ST_ADDR: begin
                n_state = tmcr_pkg::ST_CELL;
            end
            tmcr_pkg::ST_CELL: begin
                n_state = tmcr_pkg::ST_OUT;
            end
            tmcr_pkg::ST_OUT: begin
                if (!r_m_valid || m_tready) begin
                    w_out_load = 1'b1;
                    n_state    = tmcr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tmcr_pkg::ST_IDLE;
            end
        endcase
    end

    assign w_acc = s_tvalid & s_tready;

    always_comb begin
        if (w_out_load) begin
            n_m_valid = 1'b1;
        end else if (m_tready) begin
            n_m_valid = 1'b0;
        end else begin
            n_m_valid = r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tmcr_pkg::ST_CLEAR;
            r_clr     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_m_valid <= n_m_valid;
        end
    end

    // Render payload capture
    always_ff @(posedge i_clk) begin
        if (w_acc && w_req == tmcr_pkg::REQ_RENDER) begin
            r_line  <= w_line;
            r_col   <= w_column;
            r_q     <= w_q;
            r_blank <= w_blank;
        end
        if (r_state == tmcr_pkg::ST_ADDR) begin
            r_gy <= w_gy;
        end
    end

    // ------------------------------------------------------------------
    // Cell store: {attribute, char_code}
    // ------------------------------------------------------------------
    logic [15:0]        r_cell_mem [CELL_DEPTH];
    logic [15:0]        r_cell_q;
    logic               w_cell_we;
    logic [CELL_AW-1:0] w_cell_wa;
    logic [15:0]        w_cell_wd;
    logic               w_cell_re;

    always_comb begin
        if (r_state == tmcr_pkg::ST_CLEAR) begin
            w_cell_we = ({1'b0, r_clr} < CELL_DEPTH_C);
            w_cell_wa = r_clr[CELL_AW-1:0];
            w_cell_wd = '0;
        end else begin
            w_cell_we = w_acc && (w_req == tmcr_pkg::REQ_WR_CELL) && w_wr_cell_ok;
            w_cell_wa = w_wr_sum[CELL_AW-1:0];
            w_cell_wd = {w_attr, w_char};
        end
    end

    assign w_cell_re = (r_state == tmcr_pkg::ST_ADDR);

    always_ff @(posedge i_clk) begin
        if (w_cell_we) begin
            r_cell_mem[w_cell_wa] <= w_cell_wd;
        end
        if (w_cell_re) begin
            r_cell_q <= r_cell_mem[w_rd_sum[CELL_AW-1:0]];
        end
    end

    // ------------------------------------------------------------------
    // Font store: {char_code, glyph row}
    // ------------------------------------------------------------------
    logic [7:0]         r_font_mem [tmcr_pkg::FONT_DEPTH];
    logic [7:0]         r_font_q;
    logic               w_font_we;
    logic [FONT_AW-1:0] w_font_wa;
    logic [7:0]         w_font_wd;
    logic               w_font_re;

    always_comb begin
        if (r_state == tmcr_pkg::ST_CLEAR) begin
            w_font_we = ({1'b0, r_clr} < FONT_DEPTH_C);
            w_font_wa = r_clr[FONT_AW-1:0];
            w_font_wd = '0;
        end else begin
            w_font_we = w_acc && (w_req == tmcr_pkg::REQ_WR_FONT) && w_wr_font_ok;
            w_font_wa = {w_char, w_gline};
            w_font_wd = w_gbits;
        end
    end

    assign w_font_re = (r_state == tmcr_pkg::ST_CELL);

    always_ff @(posedge i_clk) begin
        if (w_font_we) begin
            r_font_mem[w_font_wa] <= w_font_wd;
        end
        if (w_font_re) begin
            r_font_q <= r_font_mem[{r_cell_q[7:0], r_gy}];
        end
    end

    // ------------------------------------------------------------------
    // Pixel expansion and output register
    // ------------------------------------------------------------------
    logic [15:0]              w_fg;
    logic [15:0]              w_bg;
    logic [M_TDATA_W_L-1:0]   w_pix;

    assign w_fg = tmcr_pkg::pal_pick(w_cfg.pal, r_cell_q[11:8]);
    assign w_bg = tmcr_pkg::pal_pick(w_cfg.pal, r_cell_q[15:12]);

    // Glyph bit 7 is the leftmost pixel
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            if (r_blank) begin
                w_pix[16*k +: 16] = '0;
            end else if (r_font_q[7-k]) begin
                w_pix[16*k +: 16] = w_fg;
            end else begin
                w_pix[16*k +: 16] = w_bg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_m_data  <= w_pix;
            r_m_blank <= r_blank;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;
    assign m_tuser  = r_m_blank;

endmodule

/* rtl/tmcr_cfg.sv */
// ============================================================================
// tmcr_cfg
// APB register bank: four palette words and the shown-rows count.
// ============================================================================
module tmcr_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tmcr_pkg::APB_AW-1:0]  paddr,
    input  logic [tmcr_pkg::APB_DW-1:0]  pwdata,
    output logic [tmcr_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output tmcr_pkg::t_cfg               o_cfg
);

    logic [3:0][63:0] r_pal;
    logic [6:0]       r_rows_shown;
    logic [2:0]       w_idx;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[5:3];
    assign w_wr   = psel & penable & pwrite;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pal        <= '0;
            r_rows_shown <= tmcr_pkg::ROWS_SHOWN_RST;
        end else if (w_wr) begin
            case (w_idx)
                tmcr_pkg::REG_PAL_LOW:      r_pal[0]     <= pwdata;
                tmcr_pkg::REG_PAL_MID_LOW:  r_pal[1]     <= pwdata;
                tmcr_pkg::REG_PAL_MID_HIGH: r_pal[2]     <= pwdata;
                tmcr_pkg::REG_PAL_HIGH:     r_pal[3]     <= pwdata;
                tmcr_pkg::REG_ROWS_SHOWN:   r_rows_shown <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (w_idx)
            tmcr_pkg::REG_PAL_LOW:      prdata = r_pal[0];
            tmcr_pkg::REG_PAL_MID_LOW:  prdata = r_pal[1];
            tmcr_pkg::REG_PAL_MID_HIGH: prdata = r_pal[2];
            tmcr_pkg::REG_PAL_HIGH:     prdata = r_pal[3];
            tmcr_pkg::REG_ROWS_SHOWN:   prdata = {57'd0, r_rows_shown};
            default:                    prdata = '0;
        endcase
    end

    assign o_cfg.pal        = r_pal;
    assign o_cfg.rows_shown = r_rows_shown;

endmodule
